>>> rtl/llba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llba_pkg
// shared widths, defaults and the controller state type of the bin assigner
// ----------------------------------------------------------------------------
package llba_pkg;

    localparam int MAX_BINS_DEF = 1024;
    localparam int CFG_W        = 11;
    localparam int WEIGHT_W     = 16;
    localparam int LOAD_W       = 32;
    localparam int BIN_W        = 10;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_ADD,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

>>> rtl/least_loaded_bin_assigner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_bin_assigner_core
// places each weight on the least loaded bin, bins kept as a min-heap in ram
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_weight, i_first_item
//  out      | output    | o_out_valid / i_out_stall | o_assigned_bin, o_max_load, o_min_load
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (bin_count)
//
//  a transaction goes from acceptance through ST_ROOT and ST_ADD, then ST_READ and
//  ST_CMP for each of the S swaps made by the sift-down, a last ST_READ, plus ST_CMP
//  when it stops on a compare without a swap, and ST_DONE; each swap is one two-port
//  ram read plus one compare-and-write step, all bin loads and labels live in the single heap ram
//  after reset and before a transaction with first_item set, a clear pass writes
//  every ram entry, with the input stalled
//  the result register frees the input side, a finished transaction waits only
//  while the previous result is still stalled
// ----------------------------------------------------------------------------
module least_loaded_bin_assigner_core #(
    parameter int MAX_BINS = llba_pkg::MAX_BINS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [llba_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                          i_first_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [llba_pkg::BIN_W-1:0]    o_assigned_bin,
    output logic      [llba_pkg::LOAD_W-1:0]   o_max_load,
    output logic      [llba_pkg::LOAD_W-1:0]   o_min_load,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [llba_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int AW     = $clog2(MAX_BINS);
    localparam int LW     = AW;
    localparam int LDW    = llba_pkg::LOAD_W;
    localparam int DW     = LW + LDW;
    localparam int CMPW   = (AW + 2 > llba_pkg::CFG_W) ? AW + 2 : llba_pkg::CFG_W + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

    llba_pkg::t_state r_state;
    llba_pkg::t_state n_state;

    logic [llba_pkg::CFG_W-1:0]    r_bin_count;
    logic [AW-1:0]                 r_clr_addr;
    logic                          r_pend;
    logic [llba_pkg::WEIGHT_W-1:0] r_weight;
    logic [AW-1:0]                 r_q;
    logic [LDW-1:0]                r_x_load;
    logic [LW-1:0]                 r_x_label;
    logic [llba_pkg::BIN_W-1:0]    r_bin;
    logic [LDW-1:0]                r_largest;
    logic [LDW-1:0]                r_min;
    logic                          r_out_valid;
    logic [llba_pkg::BIN_W-1:0]    r_out_bin;
    logic [LDW-1:0]                r_out_max;
    logic [LDW-1:0]                r_out_min;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_ra_addr;
    logic [AW-1:0]   ram_rb_addr;
    logic [DW-1:0]   ram_ra_data;
    logic [DW-1:0]   ram_rb_data;

    logic            in_acc;
    logic            out_free;
    logic [CMPW-1:0] bc_ext;
    logic [CMPW-1:0] m_act;
    logic [CMPW-1:0] left_idx;
    logic [CMPW-1:0] right_idx;
    logic            is_leaf;
    logic            pick_left;
    logic [AW-1:0]   c_idx;
    logic [DW-1:0]   c_data;
    logic            do_swap;
    logic [LDW:0]    sum;
    logic [LDW-1:0]  sum_sat;

    llba_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_BINS)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_ra_addr (ram_ra_addr),
        .o_ra_data (ram_ra_data),
        .i_rb_addr (ram_rb_addr),
        .o_rb_data (ram_rb_data)
    );

    // active bin count, zero means one, saturates at the heap size
    assign bc_ext = CMPW'(r_bin_count);
    always_comb begin
        if (bc_ext == '0) begin
            m_act = CMPW'(1);
        end else if (bc_ext > CMPW'(MAX_BINS)) begin
            m_act = CMPW'(MAX_BINS);
        end else begin
            m_act = bc_ext;
        end
    end

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign left_idx  = (CMPW'(r_q) << 1) + CMPW'(1);
    assign right_idx = left_idx + CMPW'(1);
    assign is_leaf   = left_idx >= m_act;

    // child select, right wins on equal loads
    assign pick_left = (right_idx >= m_act) ||
                       (ram_ra_data[LDW-1:0] < ram_rb_data[LDW-1:0]);
    assign c_idx     = pick_left ? left_idx[AW-1:0] : right_idx[AW-1:0];
    assign c_data    = pick_left ? ram_ra_data : ram_rb_data;
    assign do_swap   = c_data[LDW-1:0] < r_x_load;

    assign sum     = {1'b0, ram_ra_data[LDW-1:0]} + (LDW + 1)'(r_weight);
    assign sum_sat = sum[LDW] ? {LDW{1'b1}} : sum[LDW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            llba_pkg::ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = r_pend ? llba_pkg::ST_ROOT : llba_pkg::ST_IDLE;
                end
            end
            llba_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_first_item ? llba_pkg::ST_CLEAR : llba_pkg::ST_ROOT;
                end
            end
            llba_pkg::ST_ROOT: n_state = llba_pkg::ST_ADD;
            llba_pkg::ST_ADD:  n_state = llba_pkg::ST_READ;
            llba_pkg::ST_READ: begin
                n_state = is_leaf ? llba_pkg::ST_DONE : llba_pkg::ST_CMP;
            end
            llba_pkg::ST_CMP: begin
                n_state = do_swap ? llba_pkg::ST_READ : llba_pkg::ST_DONE;
            end
            llba_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = llba_pkg::ST_IDLE;
                end
            end
            default: n_state = llba_pkg::ST_CLEAR;
        endcase
    end

    // ram control and handshake outputs
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_q;
        ram_wdata   = {r_x_label, r_x_load};
        ram_ra_addr = '0;
        ram_rb_addr = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            llba_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = {LW'(r_clr_addr), {LDW{1'b0}}};
            end
            llba_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            llba_pkg::ST_ROOT: begin
                ram_ra_addr = '0;
            end
            llba_pkg::ST_ADD: begin
                ram_we = 1'b0;
            end
            llba_pkg::ST_READ: begin
                ram_ra_addr = left_idx[AW-1:0];
                ram_rb_addr = right_idx[AW-1:0];
                ram_we      = is_leaf;
            end
            llba_pkg::ST_CMP: begin
                ram_we = 1'b1;
                if (do_swap) begin
                    ram_wdata = c_data;
                end
            end
            llba_pkg::ST_DONE: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= llba_pkg::ST_CLEAR;
            r_bin_count <= llba_pkg::CFG_W'(1);
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_largest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_bin_count <= i_cfg_data;
            end

            if (in_acc) begin
                r_weight <= i_weight;
                r_pend   <= i_first_item;
                if (i_first_item) begin
                    r_largest <= '0;
                end
            end

            if (r_state == llba_pkg::ST_CLEAR) begin
                r_clr_addr <= (r_clr_addr == LAST_ADDR) ? '0 : r_clr_addr + AW'(1);
            end

            if (r_state == llba_pkg::ST_ADD) begin
                r_x_load  <= sum_sat;
                r_x_label <= ram_ra_data[DW-1:LDW];
                r_bin     <= llba_pkg::BIN_W'(ram_ra_data[DW-1:LDW]);
                r_q       <= '0;
                if (sum_sat > r_largest) begin
                    r_largest <= sum_sat;
                end
            end

            if (r_state == llba_pkg::ST_CMP && do_swap) begin
                r_q <= c_idx;
            end

            // root load after the sift is whatever lands at position zero
            if (ram_we && r_state != llba_pkg::ST_CLEAR && ram_waddr == '0) begin
                r_min <= ram_wdata[LDW-1:0];
            end

            if (r_state == llba_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_bin   <= r_bin;
                r_out_max   <= r_largest;
                r_out_min   <= r_min;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_assigned_bin = r_out_bin;
    assign o_max_load     = r_out_max;
    assign o_min_load     = r_out_min;

endmodule
`default_nettype wire

>>> rtl/llba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llba_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module llba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_ra_addr,
    output logic      [WIDTH-1:0] o_ra_data,
    input  wire logic [AW-1:0]    i_rb_addr,
    output logic      [WIDTH-1:0] o_rb_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_ra_data;
    logic [WIDTH-1:0] r_rb_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_ra_data <= r_mem[i_ra_addr];
        r_rb_data <= r_mem[i_rb_addr];
    end

    assign o_ra_data = r_ra_data;
    assign o_rb_data = r_rb_data;

endmodule
`default_nettype wire

>>> bench/least_loaded_bin_assigner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_bin_assigner_core_tb
// drives weight transactions into the bin assigner and checks every placement
// against a heap predictor kept in the bench; covers bin count extremes,
// ties, mid-stream count changes and noise sequences
// ----------------------------------------------------------------------------
module least_loaded_bin_assigner_core_tb;
    import llba_pkg::*;

    localparam int MAX_BINS = MAX_BINS_DEF;
    localparam int RANDOM_ITEMS = 1900;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                first;
    } t_weight_item;

    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [LOAD_W-1:0] max_load;
        logic [LOAD_W-1:0] min_load;
    } t_placement;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [WEIGHT_W-1:0] i_weight = '0;
    logic                i_first_item = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [BIN_W-1:0]    o_assigned_bin;
    logic [LOAD_W-1:0]   o_max_load;
    logic [LOAD_W-1:0]   o_min_load;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    least_loaded_bin_assigner_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_weight       (i_weight),
        .i_first_item   (i_first_item),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_assigned_bin (o_assigned_bin),
        .o_max_load     (o_max_load),
        .o_min_load     (o_min_load),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // bench copy of the heap
    logic [LOAD_W-1:0] bin_load [MAX_BINS];
    logic [BIN_W-1:0]  bin_label [MAX_BINS];
    logic [LOAD_W-1:0] peak_load;
    logic [CFG_W-1:0]  bin_count_reg;

    t_weight_item pending_items[$];
    t_placement   expected_placements[$];

    int  err_count = 0;
    int  result_count = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    bit  idle_on = 1'b0;
    bit  in_taken = 1'b0;
    t_placement want;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_bins();
        for (int q = 0; q < MAX_BINS; q++) begin
            bin_load[q] = '0;
            bin_label[q] = q[BIN_W-1:0];
        end
        peak_load = '0;
    endfunction

    function automatic t_placement place_weight(input logic [WEIGHT_W-1:0] w,
                                                input logic first);
        t_placement        r;
        int                active;
        int                q;
        int                left;
        int                right;
        int                pick;
        logic [LOAD_W:0]   sum;
        logic [LOAD_W-1:0] tl;
        logic [BIN_W-1:0]  tb;
        active = (bin_count_reg == 0) ? 1 :
                 (bin_count_reg > MAX_BINS) ? MAX_BINS : int'(bin_count_reg);
        if (first)
            clear_bins();
        sum = {1'b0, bin_load[0]} + {{(LOAD_W+1-WEIGHT_W){1'b0}}, w};
        bin_load[0] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
        if (bin_load[0] > peak_load)
            peak_load = bin_load[0];
        r.bin = bin_label[0];
        q = 0;
        while (2 * q + 1 < active) begin
            left = 2 * q + 1;
            right = left + 1;
            pick = (right >= active || bin_load[left] < bin_load[right]) ? left : right;
            if (!(bin_load[pick] < bin_load[q]))
                break;
            tl = bin_load[q];
            bin_load[q] = bin_load[pick];
            bin_load[pick] = tl;
            tb = bin_label[q];
            bin_label[q] = bin_label[pick];
            bin_label[pick] = tb;
            q = pick;
        end
        r.max_load = peak_load;
        r.min_load = bin_load[0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [LOAD_W-1:0] got,
                                   input logic [LOAD_W-1:0] exp_val);
        err_count++;
        $display("mismatch %s on transaction %0d: got %0h expected %0h",
                 field, result_count, got, exp_val);
    endtask

    task automatic add_item(input logic [WEIGHT_W-1:0] w, input logic first);
        t_weight_item it;
        it.weight = w;
        it.first = first;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_placements.size() != 0) begin
            @(negedge i_clk);
            #1;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_bin_count(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        bin_count_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!i_in_valid || in_taken) begin
            if (in_gap != 0) begin
                i_in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_in_valid <= 1'b0;
                in_gap <= $urandom_range(0, 8);
            end else if (pending_items.size() != 0) begin
                i_weight <= pending_items[0].weight;
                i_first_item <= pending_items[0].first;
                i_in_valid <= 1'b1;
                void'(pending_items.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap <= 0;
        end else if (out_gap != 0) begin
            i_out_stall <= 1'b1;
            out_gap <= out_gap - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            out_gap <= $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // input monitor and prediction
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_placements.push_back(place_weight(i_weight, i_first_item));
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_placements.size() == 0) begin
                report_mismatch("transaction with none expected", '0, '0);
            end else begin
                want = expected_placements.pop_front();
                if (o_assigned_bin !== want.bin)
                    report_mismatch("assigned_bin", LOAD_W'(o_assigned_bin), LOAD_W'(want.bin));
                if (o_max_load !== want.max_load)
                    report_mismatch("max_load", o_max_load, want.max_load);
                if (o_min_load !== want.min_load)
                    report_mismatch("min_load", o_min_load, want.min_load);
            end
            result_count++;
        end
    end

    initial begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int               random_count;
        int               len;
        int               kind;
        int               dec_max;
        bit               mid;
        logic [CFG_W-1:0] cfg;
        logic [WEIGHT_W-1:0] w;

        bin_count_reg = 1;
        clear_bins();
        random_count = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default single bin after reset
        add_item(16'd0, 1'b0);
        add_item(16'hFFFF, 1'b0);
        add_item(16'd1, 1'b1);
        wait_drained();
        // zero count acts as one bin
        write_bin_count(11'd0);
        add_item(16'd100, 1'b0);
        add_item(16'hFFFF, 1'b0);
        wait_drained();
        // equal loads, right child wins
        write_bin_count(11'd3);
        add_item(16'd5, 1'b1);
        add_item(16'd5, 1'b0);
        add_item(16'd5, 1'b0);
        add_item(16'd5, 1'b0);
        add_item(16'd0, 1'b0);
        add_item(16'hFFFF, 1'b0);
        wait_drained();
        // count above the heap size saturates
        write_bin_count(11'h7FF);
        add_item(16'hFFFF, 1'b1);
        add_item(16'hFFFE, 1'b0);
        add_item(16'h8000, 1'b0);
        add_item(16'd1, 1'b0);
        wait_drained();
        // count shrunk mid-stream
        write_bin_count(11'd2);
        add_item(16'd7, 1'b0);
        add_item(16'd3, 1'b0);
        add_item(16'd3, 1'b0);
        wait_drained();
        write_bin_count(11'd1024);
        add_item(16'd40000, 1'b1);
        add_item(16'd40000, 1'b0);
        wait_drained();

        // random sequences
        while (random_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       cfg = 11'd0;
                1:       cfg = 11'd1;
                2:       cfg = 11'd2;
                3:       cfg = CFG_W'($urandom_range(3, 64));
                4:       cfg = CFG_W'($urandom_range(65, 1023));
                5:       cfg = 11'd1024;
                6:       cfg = CFG_W'($urandom_range(1025, 2047));
                default: cfg = 11'h7FF;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            write_bin_count(cfg);
            len = $urandom_range(8, 48);
            kind = $urandom_range(0, 9);
            mid = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 2))
                0:       dec_max = 3;
                1:       dec_max = 255;
                default: dec_max = 8191;
            endcase
            w = WEIGHT_W'($urandom_range(0, 65535));
            for (int i = 0; i < len; i++) begin
                if (kind == 0) begin
                    // noise: unordered weights, stray clears
                    add_item(WEIGHT_W'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
                end else begin
                    add_item(w, i == 0 && !mid);
                    if (kind != 1)
                        w = (w > dec_max) ? w - WEIGHT_W'($urandom_range(0, dec_max)) : '0;
                end
            end
            random_count += len;
            wait_drained();
        end

        // full heap, falling weights, no idling
        idle_on = 1'b0;
        write_bin_count(11'd1024);
        add_item(16'hFFFF, 1'b1);
        for (int i = 0; i < 30; i++)
            add_item(WEIGHT_W'(60000 - 1000 * i), 1'b0);
        wait_drained();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
